// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== src/stpg_pkg.sv =====
// Types and constants of the step pulse generator.
`timescale 1ns / 1ps
`default_nettype none
package stpg_pkg;
  localparam int IO_AXES = 4;
  localparam int DIV_BITS = 24;
  localparam logic [4:0] DIV_CYCLES = 5'd24;
  localparam logic signed [24:0] RAMP_NEAR_END = 25'sd20000;
  localparam logic signed [13:0] RAMP_MAX_PERIOD = 14'sd2000;
  localparam logic [11:0] IDLE_PERIOD = 12'hFFF;
  localparam logic [6:0] RAMP_STEP_INIT = 7'd80;
  localparam logic [11:0] RAMP_START_PERIOD = 12'd1000;
  localparam logic [6:0] SPEED_LIMIT = 7'd100;

  localparam logic [2:0] CFG_INVERT = 3'd0;
  localparam logic [2:0] CFG_SPEED = 3'd1;
  localparam logic [2:0] CFG_WIDTH = 3'd2;
  localparam logic [2:0] CFG_RES = 3'd3;
  localparam logic [2:0] CFG_SOFT = 3'd4;

  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
    logic tick;
    logic clear;
  } lane_ctrl_t;
endpackage
`default_nettype wire

// ===== src/stpg_lane.sv =====
// One axis lane: distance, divider computation and step pulse timing.
`timescale 1ns / 1ps
`default_nettype none
module stpg_lane (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire stpg_pkg::lane_ctrl_t    ctrl,
  input  wire logic signed [14:0]      move_in,
  input  wire logic                    invert,
  input  wire logic [9:0]              pulse_width,
  input  wire logic [23:0]             product,
  output logic [14:0]                  abs_dist,
  output logic                         dir,
  output logic                         div_busy,
  output logic                         step
);
  import stpg_pkg::*;

  logic [23:0] divider;
  logic [23:0] phase;
  logic armed;
  logic signed [10:0] countdown;
  logic [23:0] quot;
  logic [15:0] rem;
  logic [4:0] cnt;
  logic signed [15:0] v;
  logic [15:0] sh;
  logic ge;
  logic [23:0] phase_next;
  logic armed_next;
  logic signed [10:0] cd_mid;
  logic signed [10:0] cd_next;
  logic step_next;

  always_comb begin
    v = invert ? -16'(move_in) : 16'(move_in);
    sh = {rem[14:0], quot[DIV_BITS-1]};
    ge = sh >= {1'b0, abs_dist};
  end

  always_comb begin
    phase_next = phase;
    armed_next = armed;
    cd_mid = countdown;
    step_next = step;
    if (divider != '0) begin
      if (phase >= divider) begin
        step_next = 1'b1;
        phase_next = 24'd1;
        armed_next = 1'b0;
      end else begin
        phase_next = phase + 24'd1;
        if (!armed) begin
          armed_next = 1'b1;
          cd_mid = $signed({1'b0, pulse_width});
        end
      end
    end
    cd_next = cd_mid;
    if (cd_mid > 11'sd0) begin
      cd_next = cd_mid - 11'sd1;
    end else if (cd_mid == 11'sd0) begin
      cd_next = -11'sd1;
      step_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dir <= ~v[15];
      abs_dist <= v[15] ? 15'(-v) : v[14:0];
    end
    if (ctrl.div_start) begin
      quot <= product;
      rem <= '0;
    end else if (div_busy) begin
      quot <= {quot[DIV_BITS-2:0], ge};
      rem <= ge ? sh - {1'b0, abs_dist} : sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider <= '0;
      phase <= '0;
      armed <= 1'b0;
      countdown <= '0;
      step <= 1'b0;
      div_busy <= 1'b0;
      cnt <= '0;
    end else begin
      if (ctrl.div_start) begin
        div_busy <= 1'b1;
        cnt <= DIV_CYCLES;
      end else if (div_busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          div_busy <= 1'b0;
        end
      end
      if (ctrl.commit) begin
        divider <= (abs_dist == '0) ? '0 : quot;
      end
      if (ctrl.tick) begin
        armed <= armed_next;
        countdown <= cd_next;
        if (ctrl.clear) begin
          phase <= '0;
          divider <= '0;
          step <= 1'b0;
        end else begin
          phase <= phase_next;
          step <= step_next;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/four_axis_step_pulse_generator_top.sv =====
// Top level of the four-axis step pulse generator.
`timescale 1ns / 1ps
`default_nettype none
// A tick item's result is ready the cycle after the item is accepted. A move item passes
// a distance stage, a maximum stage, one multiply and a 24-bit restoring divider that
// runs in every axis lane at once before its result is ready. The block takes one item
// at a time; the next item may be accepted in the cycle in which the previous result
// is taken. Configuration writes take effect at once.
module four_axis_step_pulse_generator_top #(
  parameter int AXIS_COUNT = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [9:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               req_type,
  input  wire logic signed [14:0] x_move,
  input  wire logic signed [14:0] y_move,
  input  wire logic signed [14:0] z_move,
  input  wire logic signed [14:0] a_move,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              step_pulses,
  output logic [3:0]              directions,
  output logic                    drivers_enabled,
  output logic [11:0]             timer_period,
  output logic                    busy_res,
  output logic                    move_finished
);
  import stpg_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAX = 3'd1;
  localparam logic [2:0] ST_MUL = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_DIV = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [3:0] invert_mask;
  logic [6:0] max_speed;
  logic [9:0] pulse_width;
  logic [9:0] resolution;
  logic soft_start;

  logic [2:0] state;
  logic [14:0] master;
  logic [24:0] product;
  logic [3:0] dirs;
  logic enable;
  logic signed [24:0] master_count;
  logic running;
  logic [9:0] ramp_ticks;
  logic [11:0] ramp_period;
  logic [6:0] ramp_step;
  logic [10:0] run_period;
  logic [11:0] current_period;
  logic finished;

  lane_ctrl_t ctrl;
  logic signed [14:0] moves [IO_AXES];
  logic [14:0] lane_dist [AXIS_COUNT];
  logic [AXIS_COUNT-1:0] lane_dir;
  logic [AXIS_COUNT-1:0] lane_busy;
  logic [AXIS_COUNT-1:0] lane_step;
  logic [14:0] master_next;
  logic [10:0] run_calc;
  logic out_free;
  logic out_load;
  logic take_in;
  logic tick_run;
  logic end_move;
  logic signed [13:0] rp;
  logic signed [13:0] rp_up;
  logic signed [13:0] rp_dn;
  logic signed [13:0] rp_dn_clamped;
  logic [6:0] step_dn;

  assign moves[0] = x_move;
  assign moves[1] = y_move;
  assign moves[2] = z_move;
  assign moves[3] = a_move;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign take_in = in_valid && in_ready;
  assign tick_run = take_in && (req_type == REQ_TICK) && running;
  assign end_move = master_count < 25'sd0;
  assign out_load = (take_in && (req_type == REQ_TICK)) || ((state == ST_DONE) && out_free);

  always_comb begin
    ctrl.load = take_in && (req_type == REQ_MOVE);
    ctrl.div_start = (state == ST_LOAD);
    ctrl.commit = (state == ST_DONE) && out_free;
    ctrl.tick = tick_run;
    ctrl.clear = end_move;
  end

  for (genvar i = 0; i < AXIS_COUNT; i++) begin : g_lane
    logic signed [14:0] mv;
    logic inv;
    if (i < IO_AXES) begin : g_io
      assign mv = moves[i];
      assign inv = invert_mask[i];
    end else begin : g_extra
      assign mv = '0;
      assign inv = 1'b0;
    end
    stpg_lane u_lane (
      .clk(clk),
      .rst(rst),
      .ctrl(ctrl),
      .move_in(mv),
      .invert(inv),
      .pulse_width(pulse_width),
      .product(product[23:0]),
      .abs_dist(lane_dist[i]),
      .dir(lane_dir[i]),
      .div_busy(lane_busy[i]),
      .step(lane_step[i])
    );
  end

  for (genvar i = 0; i < IO_AXES; i++) begin : g_out
    if (i < AXIS_COUNT) begin : g_on
      assign step_pulses[i] = lane_step[i];
      assign dirs[i] = lane_dir[i];
    end else begin : g_off
      assign step_pulses[i] = 1'b0;
      assign dirs[i] = 1'b0;
    end
  end

  always_comb begin
    master_next = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      if (lane_dist[i] > master_next) begin
        master_next = lane_dist[i];
      end
    end
  end

  always_comb begin
    run_calc = (max_speed >= SPEED_LIMIT) ? '0 :
               11'({4'b0, SPEED_LIMIT - max_speed} * 11'd10);
    rp = $signed({2'b0, ramp_period});
    rp_up = rp + 14'sd10;
    if (rp_up >= RAMP_MAX_PERIOD) begin
      rp_up = RAMP_MAX_PERIOD;
    end
    rp_dn = rp - $signed({7'b0, ramp_step});
    step_dn = ramp_step;
    if (ramp_step > 7'd2 && rp_dn < 14'sd100) begin
      step_dn = ramp_step - 7'd1;
    end
    rp_dn_clamped = rp_dn;
    if (rp_dn <= $signed({3'b0, run_period})) begin
      rp_dn_clamped = $signed({3'b0, run_period});
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MAX) begin
      master <= master_next;
    end
    if (state == ST_MUL) begin
      product <= 25'({10'b0, master} * {15'b0, resolution});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_mask <= 4'd2;
      max_speed <= 7'd99;
      pulse_width <= 10'd100;
      resolution <= 10'd250;
      soft_start <= 1'b0;
      state <= ST_IDLE;
      directions <= '0;
      enable <= 1'b0;
      master_count <= '0;
      running <= 1'b0;
      ramp_ticks <= '0;
      ramp_period <= '0;
      ramp_step <= '0;
      run_period <= '0;
      current_period <= IDLE_PERIOD;
      finished <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_INVERT: invert_mask <= cfg_data[3:0];
          CFG_SPEED: max_speed <= cfg_data[6:0];
          CFG_WIDTH: pulse_width <= cfg_data;
          CFG_RES: resolution <= cfg_data;
          CFG_SOFT: soft_start <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take_in) begin
            if (req_type == REQ_MOVE) begin
              state <= ST_MAX;
            end else begin
              finished <= running && end_move;
              if (!running) begin
                current_period <= IDLE_PERIOD;
              end else if (end_move) begin
                running <= 1'b0;
                directions <= '0;
                enable <= 1'b0;
                master_count <= '0;
              end else begin
                if (soft_start) begin
                  if (ramp_ticks > 10'd0) begin
                    ramp_ticks <= ramp_ticks - 10'd1;
                  end else begin
                    if (master_count < RAMP_NEAR_END) begin
                      ramp_period <= rp_up[11:0];
                      current_period <= rp_up[11:0];
                      ramp_step <= RAMP_STEP_INIT;
                    end else begin
                      ramp_period <= rp_dn_clamped[11:0];
                      current_period <= rp_dn_clamped[11:0];
                      ramp_step <= step_dn;
                    end
                    ramp_ticks <= resolution;
                  end
                end else begin
                  current_period <= {1'b0, run_period};
                end
                master_count <= master_count - 25'sd1;
              end
            end
          end
        end
        ST_MAX: state <= ST_MUL;
        ST_MUL: state <= ST_LOAD;
        ST_LOAD: state <= ST_DIV;
        ST_DIV: begin
          if (lane_busy == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
            finished <= 1'b0;
            directions <= dirs;
            enable <= 1'b1;
            master_count <= $signed(product);
            run_period <= run_calc;
            if (soft_start) begin
              ramp_ticks <= resolution;
              current_period <= RAMP_START_PERIOD;
              ramp_period <= RAMP_START_PERIOD;
              ramp_step <= RAMP_STEP_INIT;
            end else begin
              current_period <= {1'b0, run_calc};
            end
            running <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign drivers_enabled = enable;
  assign timer_period = current_period;
  assign busy_res = running;
  assign move_finished = finished;

  `CHK_IMPLY(a_enable_running, clk, rst, 1'b1, enable == running)
  `CHK_IMPLY(a_idle_no_steps, clk, rst, !running, step_pulses == 4'd0)
  `CHK_IMPLY(a_finish_stops, clk, rst, finished, !running)
  `CHK_NEXT(a_move_blocks, clk, rst, take_in && (req_type == REQ_MOVE), !in_ready)
endmodule
`default_nettype wire

// ===== verif/four_axis_step_pulse_generator_top_tb.sv =====
// Testbench of the step pulse generator: directed table and cases, then random moves and ticks.
`timescale 1ns / 1ps
module four_axis_step_pulse_generator_top_tb;
  import stpg_pkg::*;

  typedef struct packed {
    logic [3:0]  step;
    logic [3:0]  dir;
    logic        en;
    logic [11:0] period;
    logic        busy;
    logic        fin;
  } pulse_state_t;

  typedef struct {
    logic               req;
    logic signed [14:0] dx, dy, dz, da;
    bit                 typed;
    pulse_state_t       want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = CFG_INVERT;
  logic [9:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_type = REQ_TICK;
  logic signed [14:0] x_move = '0, y_move = '0, z_move = '0, a_move = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         step_pulses, directions;
  logic               drivers_enabled, busy_res, move_finished;
  logic [11:0]        timer_period;

  four_axis_step_pulse_generator_top u_top (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_ready, .req_type,
    .x_move, .y_move, .z_move, .a_move, .out_valid, .out_ready, .step_pulses,
    .directions, .drivers_enabled, .timer_period, .busy_res, .move_finished
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  logic [3:0]  inv_mask;
  logic [6:0]  speed;
  logic [9:0]  pw, res;
  logic        soft_on;
  int unsigned divider[4], phase[4];
  bit          armed[4];
  int          countdown[4];
  logic [3:0]  steps;
  logic [4:0]  dir_en;
  int          master_cnt, ramp_per, run_per;
  int unsigned ramp_left, ramp_dec;
  bit          running;
  logic [11:0] cur_period;

  pulse_state_t pending_q[$];
  int errors = 0;
  int items = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  int cycles = 0;

  function automatic pulse_state_t next_pulse_state(logic rq, logic signed [14:0] mv[4]);
    int v;
    int unsigned d[4];
    int unsigned master;
    bit fin;
    fin = 0;
    if (rq == REQ_MOVE) begin
      dir_en = 5'h10;
      master = 0;
      for (int i = 0; i < 4; i++) begin
        v = mv[i];
        if (inv_mask[i]) v = -v;
        if (v >= 0) begin
          dir_en[i] = 1'b1;
          d[i] = v;
        end else begin
          d[i] = -v;
        end
        if (d[i] > master) master = d[i];
      end
      for (int i = 0; i < 4; i++) divider[i] = d[i] != 0 ? (res * master) / d[i] : 0;
      master_cnt = master * res;
      run_per = speed >= 100 ? 0 : (100 - speed) * 10;
      if (run_per > 1000) run_per = 1000;
      if (soft_on) begin
        ramp_left = res;
        cur_period = RAMP_START_PERIOD;
        ramp_per = RAMP_START_PERIOD;
        ramp_dec = RAMP_STEP_INIT;
      end else begin
        cur_period = run_per;
      end
      running = 1;
    end else if (!running) begin
      cur_period = IDLE_PERIOD;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (divider[i] == 0) continue;
        if (phase[i] >= divider[i]) begin
          steps[i] = 1'b1;
          phase[i] = 1;
          armed[i] = 0;
        end else begin
          phase[i]++;
          if (!armed[i]) begin
            armed[i] = 1;
            countdown[i] = pw;
          end
        end
      end
      for (int i = 0; i < 4; i++) begin
        if (countdown[i] > 0) countdown[i]--;
        else if (countdown[i] == 0) begin
          countdown[i] = -1;
          steps[i] = 1'b0;
        end
      end
      if (master_cnt < 0) begin
        running = 0;
        dir_en = '0;
        steps = '0;
        master_cnt = 0;
        for (int i = 0; i < 4; i++) begin
          divider[i] = 0;
          phase[i] = 0;
        end
        fin = 1;
      end else begin
        if (soft_on) begin
          if (ramp_left > 0) ramp_left--;
          else begin
            if (master_cnt < RAMP_NEAR_END) begin
              ramp_per += 10;
              ramp_dec = RAMP_STEP_INIT;
              if (ramp_per >= RAMP_MAX_PERIOD) ramp_per = RAMP_MAX_PERIOD;
            end else begin
              ramp_per -= ramp_dec;
              if (ramp_dec > 2 && ramp_per < 100) ramp_dec--;
              if (ramp_per <= run_per) ramp_per = run_per;
            end
            cur_period = ramp_per[11:0];
            ramp_left = res;
          end
        end else begin
          cur_period = run_per;
        end
        master_cnt--;
      end
    end
    return '{steps, dir_en[3:0], dir_en[4], cur_period, running, fin};
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pulse_state_t e;
    cycles <= cycles + 1;
    if (rst) out_ready <= 1'b0;
    else out_ready <= hold_left == 0 && (stall_mode == 0 || $urandom_range(0, 9) > 3);
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (step_pulses !== e.step) report("step_pulses", step_pulses, e.step);
        if (directions !== e.dir) report("directions", directions, e.dir);
        if (drivers_enabled !== e.en) report("drivers_enabled", drivers_enabled, e.en);
        if (timer_period !== e.period) report("timer_period", timer_period, e.period);
        if (busy_res !== e.busy) report("busy_res", busy_res, e.busy);
        if (move_finished !== e.fin) report("move_finished", move_finished, e.fin);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go) hold_left <= 300;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (cycles > 600000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(logic rq, logic signed [14:0] dx, dy, dz, da,
                      bit typed = 0, pulse_state_t want = '0);
    logic signed [14:0] mv[4];
    pulse_state_t p;
    req_type <= rq;
    x_move <= dx;
    y_move <= dy;
    z_move <= dz;
    a_move <= da;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mv = '{dx, dy, dz, da};
    p = next_pulse_state(rq, mv);
    pending_q.push_back(typed ? want : p);
    items++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_INVERT: inv_mask = val[3:0];
      CFG_SPEED:  speed = val[6:0];
      CFG_WIDTH:  pw = val;
      CFG_RES:    res = val;
      CFG_SOFT:   soft_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int m, int s, int w, int r, int so);
    drain();
    write_reg(CFG_INVERT, m);
    write_reg(CFG_SPEED, s);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_RES, r);
    write_reg(CFG_SOFT, so);
  endtask

  function automatic logic signed [14:0] rand_dist(int lim);
    int v;
    v = $urandom_range(0, lim);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  stim_row_t rows[$];
  int ticks, lim, cfg_pick;

  initial begin
    inv_mask = 4'd2;
    speed = 7'd99;
    pw = 10'd100;
    res = 10'd250;
    soft_on = 0;
    for (int i = 0; i < 4; i++) begin
      divider[i] = 0;
      phase[i] = 0;
      armed[i] = 0;
      countdown[i] = 0;
    end
    steps = '0;
    dir_en = '0;
    master_cnt = 0;
    running = 0;
    ramp_left = 0;
    ramp_per = 0;
    ramp_dec = 0;
    run_per = 0;
    cur_period = IDLE_PERIOD;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    stall_mode = 1;

    rows.push_back('{REQ_TICK, 0, 0, 0, 0, 1, '{4'h0, 4'h0, 1'b0, 12'hFFF, 1'b0, 1'b0}});
    rows.push_back('{REQ_MOVE, 5, 0, -3, 9999, 1, '{4'h0, 4'hB, 1'b1, 12'd10, 1'b1, 1'b0}});
    rows.push_back('{REQ_MOVE, -9999, 9999, -9999, -9999, 0, '0});
    rows.push_back('{REQ_MOVE, 9999, -9999, 9999, 9999, 0, '0});
    rows.push_back('{REQ_MOVE, 0, 0, 0, 0, 0, '0});
    for (int i = 0; i < 3; i++) rows.push_back('{REQ_TICK, 0, 0, 0, 0, 0, '0});
    rows.push_back('{REQ_MOVE, 2, -1, 0, 1, 0, '0});
    for (int i = 0; i < 14; i++) rows.push_back('{REQ_TICK, -1, -1, -1, -1, 0, '0});
    foreach (rows[i])
      send(rows[i].req, rows[i].dx, rows[i].dy, rows[i].dz, rows[i].da,
           rows[i].typed, rows[i].want);

    // Extreme settings, including zero resolution and speed beyond the run range.
    set_config(0, 0, 0, 1, 0);
    send(REQ_MOVE, 3, -2, 1, 0);
    repeat (8) send(REQ_TICK, 0, 0, 0, 0);
    set_config(15, 127, 1023, 1023, 1);
    send(REQ_MOVE, -7, 7, 0, 3);
    repeat (10) send(REQ_TICK, 0, 0, 0, 0);
    set_config(5, 50, 3, 0, 0);
    send(REQ_MOVE, 4, 0, -4, 2);
    repeat (4) send(REQ_TICK, 0, 0, 0, 0);
    // Soft start on a long move so the ramp speeds up, then a short move so it slows.
    set_config(10, 90, 2, 3, 1);
    send(REQ_MOVE, 9999, 100, -50, 0);
    repeat (40) send(REQ_TICK, 0, 0, 0, 0);
    send(REQ_MOVE, 3, 1, 0, -2);
    repeat (30) send(REQ_TICK, 0, 0, 0, 0);

    // Long hold-off at the receiver while items keep coming.
    stall_mode = 0;
    in_valid <= 1'b0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (6) send(REQ_TICK, 0, 0, 0, 0);

    while (items < 800) begin
      cfg_pick = $urandom_range(0, 3);
      stall_mode = $urandom_range(0, 1);
      set_config($urandom_range(0, 15), cfg_pick == 0 ? 127 : $urandom_range(0, 99),
                 cfg_pick == 1 ? 1023 : $urandom_range(0, 6), $urandom_range(1, 6),
                 $urandom_range(0, 1));
      repeat ($urandom_range(2, 5)) begin
        lim = $urandom_range(0, 5) == 0 ? 9999 : $urandom_range(0, 10);
        send(REQ_MOVE, rand_dist(lim), rand_dist(lim), rand_dist(lim), rand_dist(lim));
        ticks = master_cnt + 2 + $urandom_range(0, 3);
        if ($urandom_range(0, 4) == 0) ticks = $urandom_range(0, ticks);
        if (ticks > 80) ticks = 80;
        repeat (ticks) send(REQ_TICK, rand_dist(9999), rand_dist(9999), 0, 0);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/stpg_pkg.sv
src/stpg_lane.sv
src/four_axis_step_pulse_generator_top.sv
verif/four_axis_step_pulse_generator_top_tb.sv
